// File: hw/rtl/assp_pkg.sv
// Package for the adaptive stream/stride prefetcher: constants, types, setting decode.
// No dependencies.
`default_nettype none
package assp_pkg;
  localparam int StreamEntries = 16;
  localparam int StrideEntries = 16;
  localparam int StreamIdxW = $clog2(StreamEntries);
  localparam int StrideIdxW = $clog2(StrideEntries);
  localparam int StreamCntW = $clog2(StreamEntries + 1);
  localparam int StrideCntW = $clog2(StrideEntries + 1);
  localparam logic [3:0] LastSetting = 4'd13;
  localparam logic [2:0] StrideDegree = 3'd4;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [1:0] REG_DEGREE  = 2'd0;
  localparam logic [1:0] REG_EXPLORE = 2'd1;
  localparam logic [1:0] REG_EXPLOIT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MODE, ST_STREAM, ST_STREAM_EMIT, ST_STRIDE, ST_STRIDE_EMIT, ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mode_step;
    logic stream_look;
    logic stream_emit;
    logic stride_look;
    logic stride_emit;
    logic flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic stream_on;
    logic stride_on;
    logic stream_run;
    logic stride_run;
    logic emit_busy;
  } status_t;

  function automatic logic [2:0] stream_degree_of(logic [3:0] s, logic [2:0] dflt);
    logic [2:0] d;
    if (s == 4'd0 || s > LastSetting) d = dflt;
    else if (s == 4'd1) d = 3'd0;
    else d = 3'(2 + ((s - 4'd2) >> 1));
    return d;
  endfunction

  function automatic logic [2:0] stride_degree_of(logic [3:0] s);
    return (s >= 4'd3 && s <= LastSetting && s[0]) ? StrideDegree : 3'd0;
  endfunction

  // first setting with nonzero total degree
  function automatic logic [3:0] winner_of(logic [2:0] dflt);
    return (dflt != 3'd0) ? 4'd0 : 4'd2;
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/assp_if.sv
// Channel interfaces: access request, prefetch result, configuration write.
// No dependencies.
`default_nettype none
interface assp_req_if;
  logic valid;
  logic ready;
  logic [63:0] instr_pc;
  logic [63:0] access_addr;
  modport source (output valid, instr_pc, access_addr, input ready);
  modport sink (input valid, instr_pc, access_addr, output ready);
endinterface

interface assp_rsp_if;
  logic valid;
  logic ready;
  logic [63:0] prefetch_addr;
  logic from_stride;
  logic last_of_run;
  modport source (output valid, prefetch_addr, from_stride, last_of_run, input ready);
  modport sink (input valid, prefetch_addr, from_stride, last_of_run, output ready);
endinterface

interface assp_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/assp_ctrl.sv
// Controller state machine for the prefetcher.
// Depends on assp_pkg.
`default_nettype none
module assp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_fire,
  input  wire assp_pkg::status_t sts,
  output assp_pkg::cmd_t        cmd,
  output logic                  in_ready
);
  import assp_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_fire) state_next = ST_MODE;
      ST_MODE:   state_next = ST_STREAM;
      ST_STREAM: state_next = ST_STREAM_EMIT;
      ST_STREAM_EMIT: if (!sts.stream_run) state_next = ST_STRIDE;
      ST_STRIDE: state_next = ST_STRIDE_EMIT;
      ST_STRIDE_EMIT: if (!sts.stride_run) state_next = ST_DONE;
      ST_DONE:   if (!sts.emit_busy) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        cmd.load = in_fire;
      end
      ST_MODE: cmd.mode_step = 1'b1;
      ST_STREAM: cmd.stream_look = sts.stream_on;
      ST_STREAM_EMIT: cmd.stream_emit = sts.stream_run;
      ST_STRIDE: cmd.stride_look = sts.stride_on;
      ST_STRIDE_EMIT: cmd.stride_emit = sts.stride_run;
      ST_DONE: cmd.flush = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: hw/rtl/assp_dp.sv
// Datapath: mode machine, stream and stride tables, recency lists, output register.
// Depends on assp_pkg and assp_if.
`default_nettype none
module assp_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire assp_pkg::cmd_t    cmd,
  output assp_pkg::status_t      sts,
  input  wire logic [63:0]       in_pc,
  input  wire logic [63:0]       in_addr,
  assp_cfg_if.sink               cfg,
  assp_rsp_if.source             rsp
);
  import assp_pkg::*;

  logic [2:0]  dflt_deg;
  logic [15:0] explore_len, exploit_len;
  logic        exploit_mode;
  logic [3:0]  setting_index;
  logic [15:0] epoch_count;

  logic [63:0] pc_q;
  logic [51:0] page_q;
  logic [57:0] line_q;
  logic [5:0]  off_q;

  logic [51:0] s_page  [StreamEntries];
  logic [5:0]  s_off   [StreamEntries];
  logic [1:0]  s_dir   [StreamEntries];
  logic [StreamIdxW-1:0] s_ord [StreamEntries];
  logic [StreamCntW-1:0] s_used;

  logic [63:0] t_pc    [StrideEntries];
  logic [57:0] t_line  [StrideEntries];
  logic [58:0] t_delta [StrideEntries];
  logic [StrideIdxW-1:0] t_ord [StrideEntries];
  logic [StrideCntW-1:0] t_used;

  logic        run_dir_up;
  logic [58:0] run_step;
  logic [6:0]  run_pos;
  logic [2:0]  run_left;
  logic        s_run, t_run;

  logic [63:0] o_addr;
  logic        o_stride, o_valid;

  logic        h_valid;
  logic [63:0] h_addr;
  logic        h_stride;
  logic        h_last;

  logic [2:0] sdeg, tdeg;
  assign sdeg = stream_degree_of(setting_index, dflt_deg);
  assign tdeg = stride_degree_of(setting_index);

  assign cfg.ready = !rst;
  always_ff @(posedge clk) begin
    if (rst) begin
      dflt_deg <= 3'd4;
      explore_len <= 16'd1000;
      exploit_len <= 16'd10000;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DEGREE:  dflt_deg <= cfg.data[2:0];
        REG_EXPLORE: explore_len <= cfg.data;
        REG_EXPLOIT: exploit_len <= cfg.data;
        default: ;
      endcase
    end
  end

  // stream lookup
  logic                  s_hit;
  logic [StreamIdxW-1:0] s_pos, s_slot;
  always_comb begin
    s_hit = 1'b0;
    s_pos = '0;
    for (int p = StreamEntries - 1; p >= 0; p--) begin
      if (StreamCntW'(p) < s_used && s_page[s_ord[p]] == page_q) begin
        s_hit = 1'b1;
        s_pos = StreamIdxW'(p);
      end
    end
    s_slot = s_ord[s_pos];
  end

  logic                  t_hit;
  logic [StrideIdxW-1:0] t_pos, t_slot;
  always_comb begin
    t_hit = 1'b0;
    t_pos = '0;
    for (int p = StrideEntries - 1; p >= 0; p--) begin
      if (StrideCntW'(p) < t_used && t_pc[t_ord[p]] == pc_q) begin
        t_hit = 1'b1;
        t_pos = StrideIdxW'(p);
      end
    end
    t_slot = t_ord[t_pos];
  end

  // new-entry position: end of list if room, else LRU
  logic [StreamIdxW-1:0] s_new_pos;
  logic [StrideIdxW-1:0] t_new_pos;
  assign s_new_pos = (s_used < StreamCntW'(StreamEntries)) ? s_used[StreamIdxW-1:0]
                                                            : StreamIdxW'(StreamEntries - 1);
  assign t_new_pos = (t_used < StrideCntW'(StrideEntries)) ? t_used[StrideIdxW-1:0]
                                                            : StrideIdxW'(StrideEntries - 1);

  logic [1:0]  s_dir_new;
  assign s_dir_new = (off_q > s_off[s_slot]) ? DIR_UP : DIR_DOWN;
  logic [58:0] t_delta_new;
  assign t_delta_new = 59'({1'b0, line_q}) - 59'({1'b0, t_line[t_slot]});

  logic [6:0] next_pos;
  assign next_pos = s_run ? (run_dir_up ? run_pos + 7'd1 : run_pos - 7'd1)
                          : run_pos + run_step[6:0];
  logic next_in;
  assign next_in = s_run ? !next_pos[6]
                  : (!next_pos[6] && (run_step[58:6] == '0 || run_step[58:6] == '1));
  // stride offsets: step in [-63,63] else immediately out; page exit tracked in next_pos[6]

  // o_* holds the newest prefetch until it is known whether another follows
  logic h_free, emit_cmd, emit_stop, emit_fire, flush_fire, h_load;
  assign h_free = !h_valid || rsp.ready;
  assign emit_cmd = cmd.stream_emit || cmd.stride_emit;
  assign emit_stop = emit_cmd && (run_left == '0 || !next_in);
  assign emit_fire = emit_cmd && !emit_stop && (!o_valid || h_free);
  assign flush_fire = cmd.flush && o_valid && h_free;
  assign h_load = o_valid && h_free && (emit_fire || cmd.flush);

  always_ff @(posedge clk) begin
    logic [StreamIdxW-1:0] sv;
    logic [StrideIdxW-1:0] tv;
    if (rst) begin
      exploit_mode <= 1'b0;
      setting_index <= '0;
      epoch_count <= '0;
      s_used <= '0;
      t_used <= '0;
      s_run <= 1'b0;
      t_run <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        pc_q <= in_pc;
        page_q <= in_addr[63:12];
        line_q <= in_addr[63:6];
        off_q <= in_addr[11:6];
      end
      if (cmd.mode_step) begin
        if (exploit_mode) begin
          if (epoch_count + 16'd1 >= exploit_len) begin
            exploit_mode <= 1'b0;
            setting_index <= '0;
            epoch_count <= '0;
          end else epoch_count <= epoch_count + 16'd1;
        end else if (epoch_count + 16'd1 >= explore_len) begin
          if (setting_index >= LastSetting) begin
            exploit_mode <= 1'b1;
            setting_index <= winner_of(dflt_deg);
          end else setting_index <= setting_index + 4'd1;
          epoch_count <= '0;
        end else epoch_count <= epoch_count + 16'd1;
      end
      if (cmd.stream_look) begin
        if (!s_hit) begin
          sv = s_ord[s_new_pos];
          if (s_used < StreamCntW'(StreamEntries)) sv = s_used[StreamIdxW-1:0];
          for (int p = 1; p < StreamEntries; p++)
            if (StreamIdxW'(p) <= s_new_pos) s_ord[p] <= s_ord[p-1];
          s_ord[0] <= sv;
          if (s_used < StreamCntW'(StreamEntries)) s_used <= s_used + 1'b1;
          s_page[sv] <= page_q;
          s_off[sv] <= off_q;
          s_dir[sv] <= DIR_NONE;
        end else if (off_q != s_off[s_slot]) begin
          s_off[s_slot] <= off_q;
          s_dir[s_slot] <= s_dir_new;
          for (int p = 1; p < StreamEntries; p++)
            if (StreamIdxW'(p) <= s_pos) s_ord[p] <= s_ord[p-1];
          s_ord[0] <= s_slot;
          if (s_dir_new == s_dir[s_slot]) begin
            s_run <= 1'b1;
            run_dir_up <= (s_dir_new == DIR_UP);
            run_pos <= {1'b0, off_q};
            run_left <= sdeg;
          end
        end
      end
      if (cmd.stride_look) begin
        if (!t_hit) begin
          tv = t_ord[t_new_pos];
          if (t_used < StrideCntW'(StrideEntries)) tv = t_used[StrideIdxW-1:0];
          for (int p = 1; p < StrideEntries; p++)
            if (StrideIdxW'(p) <= t_new_pos) t_ord[p] <= t_ord[p-1];
          t_ord[0] <= tv;
          if (t_used < StrideCntW'(StrideEntries)) t_used <= t_used + 1'b1;
          t_pc[tv] <= pc_q;
          t_line[tv] <= line_q;
          t_delta[tv] <= '0;
        end else begin
          if (t_delta_new != '0 && t_delta_new == t_delta[t_slot]) begin
            t_run <= 1'b1;
            run_step <= t_delta_new;
            run_pos <= {1'b0, off_q};
            run_left <= tdeg;
          end
          t_delta[t_slot] <= t_delta_new;
          t_line[t_slot] <= line_q;
          for (int p = 1; p < StrideEntries; p++)
            if (StrideIdxW'(p) <= t_pos) t_ord[p] <= t_ord[p-1];
          t_ord[0] <= t_slot;
        end
      end
      if (emit_stop) begin
        s_run <= 1'b0;
        t_run <= 1'b0;
      end
      if (emit_fire) begin
        o_valid <= 1'b1;
        o_addr <= {page_q, next_pos[5:0], 6'd0};
        o_stride <= cmd.stride_emit;
        run_pos <= next_pos;
        run_left <= run_left - 3'd1;
      end else if (flush_fire) begin
        o_valid <= 1'b0;
      end
    end
  end

  // visible output register; the flushed prefetch closes the access
  always_ff @(posedge clk) begin
    if (rst) h_valid <= 1'b0;
    else if (h_load) begin
      h_valid <= 1'b1;
      h_addr <= o_addr;
      h_stride <= o_stride;
      h_last <= cmd.flush;
    end else if (rsp.ready) h_valid <= 1'b0;
  end

  assign rsp.valid = h_valid;
  assign rsp.prefetch_addr = h_addr;
  assign rsp.from_stride = h_stride;
  assign rsp.last_of_run = h_last;

  assign sts.stream_on = sdeg != '0;
  assign sts.stride_on = tdeg != '0;
  assign sts.stream_run = s_run;
  assign sts.stride_run = t_run;
  assign sts.emit_busy = h_valid || o_valid;
endmodule
`default_nettype wire

// File: hw/rtl/adaptive_stream_stride_prefetcher.sv
// Top level of the adaptive stream/stride prefetcher.
// Depends on assp_pkg, assp_if, assp_ctrl, assp_dp.
//
// Use: one access request (instr_pc, access_addr) on req; up to eleven
// prefetch requests leave on rsp, stream ones first, last_of_run on the final.
// cfg writes registers 0..2 and is ready outside reset; write only while idle.
// The controller visits mode, stream lookup, stream emission, stride lookup,
// stride emission and flush steps in turn, and emits one line a cycle while
// the receiver keeps rsp.ready high.
// A new access is taken once the previous one's prefetches have all left.
// Reset empties both tables and returns to exploring with the default setting.
// A stalled receiver holds the output register and the emission run waits.
`default_nettype none
module adaptive_stream_stride_prefetcher (
  input wire logic   clk,
  input wire logic   rst,
  assp_req_if.sink   req,
  assp_rsp_if.source rsp,
  assp_cfg_if.sink   cfg
);
  import assp_pkg::*;
  cmd_t    cmd;
  status_t sts;
  logic    in_ready;

  assign req.ready = in_ready;

  assp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(req.valid && in_ready),
    .sts(sts), .cmd(cmd), .in_ready(in_ready)
  );

  assp_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_pc(req.instr_pc), .in_addr(req.access_addr), .cfg(cfg), .rsp(rsp)
  );
endmodule
`default_nettype wire
